// File: hdl/modexp_pkg.sv
// Package for the modular exponentiation block: operand width, counter width and operand type.
// No dependencies.
package modexp_pkg;
  localparam int OperandBits = 31;
  localparam int CountBits = $clog2(OperandBits + 1);
  typedef logic [OperandBits-1:0] opnd_t;
endpackage

// File: hdl/modexp_if.sv
// Valid/ready channel interfaces for the modular exponentiation block.
// Depends on modexp_pkg.
interface modexp_in_if;
  import modexp_pkg::*;
  logic valid;
  logic ready;
  opnd_t base;
  opnd_t exponent;
  modport source (output valid, output base, output exponent, input ready);
  modport sink (input valid, input base, input exponent, output ready);
endinterface

interface modexp_out_if;
  import modexp_pkg::*;
  logic valid;
  logic ready;
  opnd_t result;
  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface

// File: hdl/modular_exponentiation.sv
// Modular exponentiation top level: right-to-left square-and-multiply with
// bit-serial shift-and-add modular multiplication. Depends on modexp_pkg, modexp_if.
// The base is first reduced by a shift-and-add pass, then for each exponent bit up to the
// highest set one there is a multiply pass when the bit is set plus a squaring pass.
// One item at a time, next beat only after the result has been taken.
// A zero exponent or zero modulus answers without any pass. Reset sets modulus to 1 and idles.
module modular_exponentiation (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  modexp_pkg::opnd_t cfg_wdata,
  modexp_in_if.sink  in_ch,
  modexp_out_if.source out_ch
);
  import modexp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SQR  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state;
  opnd_t modulus, acc, power, expo, mul_a, mul_b, racc;
  logic [CountBits-1:0] cnt;
  logic [OperandBits:0] dbl, dbl_red, add, add_red;
  logic [OperandBits:0] mext;
  opnd_t step_val;

  // One shift-and-add step: racc = 2*racc (+ a if top bit of b) mod m.
  always_comb begin
    mext = {1'b0, modulus};
    dbl = {racc, 1'b0};
    dbl_red = (dbl >= mext) ? dbl - mext : dbl;
    add = dbl_red + {1'b0, mul_a};
    add_red = (add >= mext) ? add - mext : add;
    step_val = mul_b[OperandBits-1] ? add_red[OperandBits-1:0] : dbl_red[OperandBits-1:0];
  end

  assign in_ch.ready = (state == S_IDLE) && !out_ch.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      modulus <= opnd_t'(1);
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_we) modulus <= cfg_wdata;
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            expo <= in_ch.exponent;
            if (in_ch.exponent == '0) begin
              out_ch.result <= opnd_t'(1);
              out_ch.valid <= 1'b1;
            end else if (modulus == '0) begin
              out_ch.result <= '0;
              out_ch.valid <= 1'b1;
            end else begin
              // reduce base as (1 mod m) * base, scanning the base bits; acc = 1 mod m
              acc <= (modulus == opnd_t'(1)) ? '0 : opnd_t'(1);
              mul_a <= (modulus == opnd_t'(1)) ? '0 : opnd_t'(1);
              mul_b <= in_ch.base;
              racc <= '0;
              cnt <= '0;
              state <= S_RED;
            end
          end
        end
        S_RED, S_MUL, S_SQR: begin
          if (cnt != CountBits'(OperandBits)) begin
            racc <= step_val;
            mul_b <= {mul_b[OperandBits-2:0], 1'b0};
            cnt <= cnt + 1'b1;
          end else begin
            cnt <= '0;
            racc <= '0;
            if (state == S_RED) begin
              // racc holds base mod m: start the power from it
              power <= racc;
              mul_a <= expo[0] ? acc : racc;
              mul_b <= racc;
              state <= expo[0] ? S_MUL : S_SQR;
            end else if (state == S_MUL) begin
              acc <= racc;
              mul_a <= power;
              mul_b <= power;
              state <= S_SQR;
            end else begin
              power <= racc;
              expo <= expo >> 1;
              if (expo[OperandBits-1:1] == '0) begin
                out_ch.result <= acc;
                out_ch.valid <= 1'b1;
                state <= S_IDLE;
              end else begin
                mul_a <= expo[1] ? acc : racc;
                mul_b <= racc;
                state <= expo[1] ? S_MUL : S_SQR;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("accepted while busy");
  assert property (@(posedge clk) disable iff (rst) (state != S_IDLE) |-> !out_ch.valid)
    else $error("result shown while working");
  assert property (@(posedge clk) disable iff (rst) (state == S_MUL || state == S_SQR)
    |-> (racc < modulus)) else $error("partial product unreduced");
endmodule

// File: sim/modular_exponentiation_tb.sv
// Testbench for modular_exponentiation: drives base/exponent beats under several
// modulus settings and checks each result against a square-and-multiply predictor.
// Depends on modexp_pkg, modexp_if and the RTL top level.
module modular_exponentiation_tb;
  import modexp_pkg::*;

  class modexp_scoreboard;
    opnd_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // Reduce a*b mod m, all operands below 2^31, so 64-bit math is safe.
    function longint unsigned mul_reduce(longint unsigned a,
                                         longint unsigned b,
                                         longint unsigned m);
      return (a * b) % m;
    endfunction

    function opnd_t power_mod(opnd_t b, opnd_t e, opnd_t m);
      longint unsigned acc, pw, mm;
      opnd_t ee;
      if (e == 0) return opnd_t'(1);
      if (m == 0) return opnd_t'(0);
      mm = m;
      acc = 1 % mm;
      pw = b % mm;
      ee = e;
      while (ee != 0) begin
        if (ee[0]) acc = mul_reduce(acc, pw, mm);
        pw = mul_reduce(pw, pw, mm);
        ee = ee >> 1;
      end
      return opnd_t'(acc);
    endfunction

    function void note_input(opnd_t b, opnd_t e, opnd_t m);
      pending.push_back(power_mod(b, e, m));
    endfunction

    function void check_result(opnd_t got);
      opnd_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %0d", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: result mismatch expected %0d actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, cfg_we;
  opnd_t cfg_wdata;
  opnd_t modulus_now;
  longint cycles;
  modexp_scoreboard sb;
  modexp_in_if in_ch();
  modexp_out_if out_ch();

  modular_exponentiation dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic opnd_t rand_opnd();
    opnd_t v;
    v = opnd_t'($urandom);
    case ($urandom_range(0, 5))
      0: v = v & 31'h0000_00ff;
      1: v = v & 31'h0000_ffff;
      default: ;
    endcase
    return v;
  endfunction

  // Sink side: random stalls, check every beat.
  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (!rst) out_ch.ready = (gap_len() == 0) || ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk)
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.result);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3_000_000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(opnd_t b, opnd_t e);
    int g;
    g = gap_len();
    repeat (g) @(negedge clk);
    in_ch.base = b;
    in_ch.exponent = e;
    in_ch.valid = 1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(b, e, modulus_now);
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2200) @(posedge clk);
  endtask

  task automatic set_modulus(opnd_t m);
    @(negedge clk);
    cfg_we = 1;
    cfg_wdata = m;
    modulus_now = m;
    @(negedge clk);
    cfg_we = 0;
  endtask

  opnd_t mods[8];

  initial begin
    sb = new();
    cycles = 0;
    rst = 1;
    cfg_we = 0;
    cfg_wdata = 0;
    modulus_now = 1;
    in_ch.valid = 0;
    in_ch.base = 0;
    in_ch.exponent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Reset modulus of 1: zero exponent still gives 1.
    send_item(31'd5, 31'd0);
    send_item(31'd5, 31'd3);
    drain();

    set_modulus(31'h7fff_ffff);
    send_item(31'd0, 31'd0);
    send_item(31'd0, 31'd5);
    send_item(31'h7fff_ffff, 31'h7fff_ffff);
    send_item(31'h7fff_fffe, 31'h7fff_ffff);
    send_item(31'd2, 31'd30);
    send_item(31'd3, 31'd1);
    send_item(31'h5555_5555, 31'h2aaa_aaaa);
    send_item(31'h2aaa_aaaa, 31'h5555_5555);
    drain();

    // Unreduced base, small modulus.
    set_modulus(31'd7);
    send_item(31'h7fff_ffff, 31'd12);
    send_item(31'd100, 31'h7fff_ffff);
    send_item(31'd14, 31'd3);
    drain();

    // Zero modulus is out of range but defined.
    set_modulus(31'd0);
    send_item(31'd9, 31'd4);
    send_item(31'd9, 31'd0);
    drain();

    mods[0] = 31'd1;
    mods[1] = 31'd2;
    mods[2] = 31'd46349;
    mods[3] = 31'h7fff_ffff;
    mods[4] = 31'h7fff_ffed;
    mods[5] = 31'd65537;
    for (int ph = 0; ph < 7; ph++) begin
      if (ph < 6) set_modulus(mods[ph]);
      else set_modulus(opnd_t'($urandom) | 31'h4000_0001);
      for (int i = 0; i < 40; i++) begin
        opnd_t e;
        e = rand_opnd();
        if ($urandom_range(0, 9) == 0) e = opnd_t'($urandom_range(0, 3));
        send_item(rand_opnd(), e);
      end
      drain();
    end

    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

// File: modular_exponentiation.f
hdl/modexp_pkg.sv
hdl/modexp_if.sv
hdl/modular_exponentiation.sv
sim/modular_exponentiation_tb.sv
